[design/bps_pkg.sv]
// ----------------------------------------------------------------------------
// bps_pkg: shared definitions for the byte pattern search core
// Holds widths, request codes, register indexes and the structs that
// connect the pattern bank, the window cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

    // Longest pattern that the cell row can hold.
    localparam int PAT_MAX = 64;
    // One extra cell keeps the byte just before a full-length match.
    localparam int CELL_N  = PAT_MAX + 1;

    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 6;
    localparam int LEN_W   = 7;
    localparam int FUNC_W  = 2;
    localparam int OFF_W   = 32;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Depth of the result queue in front of the master port.
    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_PTR_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DATA = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EOS  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GUARD  = 2'd1;

    localparam logic [BYTE_W-1:0] SLASH_BYTE = 8'h2F;

    // Pattern side of one window cell.
    typedef struct packed {
        logic [BYTE_W-1:0] pat_byte;
        logic              active;
        logic              border;
    } cell_pat_t;

    // Shift and clear strobes shared by every cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Per-cell compare results.
    typedef struct packed {
        logic hit;
        logic slash_edge;
    } cell_stat_t;

    // Length zero behaves as one, lengths beyond the row behave as the row.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > LEN_W'(PAT_MAX)) begin
            res = LEN_W'(PAT_MAX);
        end else begin
            res = len;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[design/bps_cell.sv]
// ----------------------------------------------------------------------------
// bps_cell: one window cell
// Holds one stream byte of the recent window and compares it against the
// pattern byte aligned to its position.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_cell import bps_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl_i,
    input  logic [BYTE_W-1:0] byte_i,
    input  logic              valid_i,
    input  cell_pat_t         pat_i,
    output logic [BYTE_W-1:0] byte_o,
    output logic              valid_o,
    output cell_stat_t        stat_o
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              valid_reg;
    logic              valid_next;

    always_comb begin
        byte_next  = byte_reg;
        valid_next = valid_reg;
        if (ctrl_i.clear) begin
            valid_next = 1'b0;
        end else if (ctrl_i.shift) begin
            byte_next  = byte_i;
            valid_next = valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    // A cell outside the pattern never blocks a match.
    assign stat_o.hit        = !pat_i.active || (valid_reg && (byte_reg == pat_i.pat_byte));
    assign stat_o.slash_edge = pat_i.border && valid_reg && (byte_reg == SLASH_BYTE);

    assign byte_o  = byte_reg;
    assign valid_o = valid_reg;

endmodule

`default_nettype wire

[design/bps_pat.sv]
// ----------------------------------------------------------------------------
// bps_pat: pattern bank
// Keeps the loaded pattern in reverse order and a copy aligned to the window
// cells for the active length, so that cell a sees pattern byte len-1-a.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_pat import bps_pkg::*; (
    input  logic                    aclk,
    input  logic [LEN_W-1:0]        act_len_i,
    input  logic                    load_en_i,
    input  logic [IDX_W-1:0]        load_idx_i,
    input  logic [BYTE_W-1:0]       load_byte_i,
    input  logic                    realign_i,
    output cell_pat_t [CELL_N-1:0]  pat_o
);

    logic [PAT_MAX-1:0][BYTE_W-1:0] raw_reg;
    logic [PAT_MAX-1:0][BYTE_W-1:0] raw_next;
    logic [PAT_MAX-1:0][BYTE_W-1:0] aligned_reg;
    logic [PAT_MAX-1:0][BYTE_W-1:0] aligned_next;

    logic [PAT_MAX*BYTE_W-1:0] raw_flat;
    logic [PAT_MAX*BYTE_W-1:0] shifted_flat;
    logic [LEN_W-1:0]          shift_amt;
    logic                      idx_ok;
    logic                      idx_in_len;
    logic [LEN_W-1:0]          al_pos_full;
    logic [IDX_W-1:0]          al_pos;
    logic [IDX_W-1:0]          raw_pos;

    // raw_reg[i] holds pattern byte PAT_MAX-1-i, so the aligned copy is the
    // raw word moved down by PAT_MAX-len bytes.
    assign raw_flat     = raw_reg;
    assign shift_amt    = LEN_W'(PAT_MAX) - act_len_i;
    assign shifted_flat = raw_flat >> {shift_amt, 3'b000};

    assign idx_ok      = {1'b0, load_idx_i} < (IDX_W+1)'(PAT_MAX);
    assign idx_in_len  = LEN_W'(load_idx_i) < act_len_i;
    assign al_pos_full = act_len_i - LEN_W'(1) - LEN_W'(load_idx_i);
    assign al_pos      = al_pos_full[IDX_W-1:0];
    assign raw_pos     = IDX_W'(PAT_MAX - 1) - load_idx_i;

    always_comb begin
        raw_next     = raw_reg;
        aligned_next = aligned_reg;
        if (realign_i) begin
            aligned_next = shifted_flat;
        end else if (load_en_i && idx_ok) begin
            raw_next[raw_pos] = load_byte_i;
            if (idx_in_len) begin
                aligned_next[al_pos] = load_byte_i;
            end
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg     <= raw_next;
        aligned_reg <= aligned_next;
    end

    for (genvar a = 0; a < CELL_N; a++) begin : g_pat
        if (a < PAT_MAX) begin : g_body
            assign pat_o[a].pat_byte = aligned_reg[a];
            assign pat_o[a].active   = LEN_W'(a) < act_len_i;
        end else begin : g_edge
            assign pat_o[a].pat_byte = '0;
            assign pat_o[a].active   = 1'b0;
        end
        assign pat_o[a].border = act_len_i == LEN_W'(a);
    end

endmodule

`default_nettype wire

[design/byte_pattern_search_core.sv]
// ----------------------------------------------------------------------------
// byte_pattern_search_core: streaming substring search
// Scans a byte stream against a loaded pattern and returns the stream offset
// of the first byte of every accepted match.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                                   Handshake
//  s_       in         tuser: func; tdata: value, pattern_index  s_tvalid/s_tready
//  m_       out        tdata: match_offset                        m_tvalid/m_tready
//  cfg_     in         cfg_index, cfg_data                        cfg_valid/cfg_ready
//
//  Requests are accepted while s_tready is high: a new byte can be accepted
//  on every clock, limited by the 65-cell compare row and its combinational AND reduction.
//  A match is decided in the cycle after its last byte is accepted, and it is
//  released into the result queue in the cycle after the following data byte
//  or end-of-stream request is accepted, since the byte after the match may
//  still reject it. aresetn (synchronous, active low) clears the window, offset
//  counter, pending match, queue and registers; pattern bytes stay undefined
//  until loaded. s_tready falls while the result queue is full, or while it
//  holds two results and a data or end-of-stream request sits in the decision
//  stage, and while the pattern bank realigns after a pattern_length write.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_pattern_search_core import bps_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] value, [13:8] pattern_index, [15:14] zero
    input  logic [FUNC_W-1:0]     s_tuser,   // [1:0] func

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] match_offset

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Input request decode.
    logic                in_acc;
    logic [FUNC_W-1:0]   in_func;
    logic [BYTE_W-1:0]   in_byte;
    logic [IDX_W-1:0]    in_idx;
    logic                is_load;
    logic                is_data;
    logic                is_eos;

    assign in_func = s_tuser;
    assign in_byte = s_tdata[BYTE_W-1:0];
    assign in_idx  = s_tdata[BYTE_W+IDX_W-1:BYTE_W];
    assign in_acc  = s_tvalid && s_tready;
    assign is_load = in_acc && (in_func == FUNC_LOAD);
    assign is_data = in_acc && (in_func == FUNC_DATA);
    assign is_eos  = in_acc && (in_func == FUNC_EOS);

    // Configuration registers. A length write triggers a realign of the pattern
    // bank, during which requests and writes are held off.
    logic                   cfg_acc;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic                   guard_reg;
    logic                   guard_next;
    logic                   realign_reg;
    logic                   realign_next;
    logic [LEN_W-1:0]       act_len;

    assign cfg_ready = !realign_reg;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign act_len   = clamp_len(len_reg);

    always_comb begin
        len_next     = len_reg;
        guard_next   = guard_reg;
        realign_next = 1'b0;
        if (cfg_acc) begin
            case (cfg_index)
                CFG_IDX_LENGTH: begin
                    len_next     = cfg_data[LEN_W-1:0];
                    realign_next = 1'b1;
                end
                CFG_IDX_GUARD: begin
                    guard_next = cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Pattern bank and the row of window cells.
    cell_pat_t [CELL_N-1:0]    cell_pat;
    cell_ctrl_t                cell_ctrl;
    cell_stat_t [CELL_N-1:0]   cell_stat;
    logic [CELL_N-1:0][BYTE_W-1:0] cell_byte;
    logic [CELL_N-1:0]         cell_valid;
    logic [CELL_N-1:0]         hit_vec;
    logic [CELL_N-1:0]         slash_vec;

    bps_pat u_pat (
        .aclk        (aclk),
        .act_len_i   (act_len),
        .load_en_i   (is_load),
        .load_idx_i  (in_idx),
        .load_byte_i (in_byte),
        .realign_i   (realign_reg),
        .pat_o       (cell_pat)
    );

    assign cell_ctrl.shift = is_data;
    assign cell_ctrl.clear = is_eos;

    // Cell 0 takes the newest byte; each later cell takes its left neighbor,
    // so cell a always holds the byte that arrived a bytes ago.
    for (genvar a = 0; a < CELL_N; a++) begin : g_cell
        if (a == 0) begin : g_head
            bps_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl_i  (cell_ctrl),
                .byte_i  (in_byte),
                .valid_i (1'b1),
                .pat_i   (cell_pat[a]),
                .byte_o  (cell_byte[a]),
                .valid_o (cell_valid[a]),
                .stat_o  (cell_stat[a])
            );
        end else begin : g_tail
            bps_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl_i  (cell_ctrl),
                .byte_i  (cell_byte[a-1]),
                .valid_i (cell_valid[a-1]),
                .pat_i   (cell_pat[a]),
                .byte_o  (cell_byte[a]),
                .valid_o (cell_valid[a]),
                .stat_o  (cell_stat[a])
            );
        end
        assign hit_vec[a]   = cell_stat[a].hit;
        assign slash_vec[a] = cell_stat[a].slash_edge;
    end

    // Stream offset counter: counts data bytes, clears on end of stream, wraps naturally.
    logic [OFF_W-1:0] seen_reg;
    logic [OFF_W-1:0] seen_next;

    always_comb begin
        seen_next = seen_reg;
        if (is_eos) begin
            seen_next = '0;
        end else if (is_data) begin
            seen_next = seen_reg + OFF_W'(1);
        end
    end

    // Stage 1 keeps the data or end-of-stream request that just updated the window, so stage 2 can
    // judge the window it left and the match it may release.
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [FUNC_W-1:0] s1_func_reg;
    logic [BYTE_W-1:0] s1_byte_reg;

    assign s1_valid_next = is_data || is_eos;

    // Stage 2: release or drop the pending match, then, on a data byte, look for a new one.
    logic              all_hit;
    logic              before_slash;
    logic              emit;
    logic              pend_reg;
    logic              pend_next;
    logic [OFF_W-1:0]  pend_start_reg;
    logic [OFF_W-1:0]  pend_start_next;

    assign all_hit      = &hit_vec;
    assign before_slash = |slash_vec;

    always_comb begin
        emit            = 1'b0;
        pend_next       = pend_reg;
        pend_start_next = pend_start_reg;
        if (s1_valid_reg) begin
            case (s1_func_reg)
                FUNC_EOS: begin
                    emit      = pend_reg;
                    pend_next = 1'b0;
                end
                FUNC_DATA: begin
                    // A slash right after the match rejects it in guarded mode.
                    emit      = pend_reg && !(guard_reg && (s1_byte_reg == SLASH_BYTE));
                    pend_next = all_hit && !(guard_reg && before_slash);
                    if (pend_next) begin
                        pend_start_next = seen_reg - OFF_W'(act_len);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result queue. Three entries cover one result in stage 2 plus two
    // waiting, which keeps s_tready free of any path from m_tready.
    logic [M_TDATA_W-1:0]  q_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] q_wr_reg;
    logic [OUTQ_PTR_W-1:0] q_wr_next;
    logic [OUTQ_PTR_W-1:0] q_rd_reg;
    logic [OUTQ_PTR_W-1:0] q_rd_next;
    logic [OUTQ_PTR_W-1:0] q_cnt_reg;
    logic [OUTQ_PTR_W-1:0] q_cnt_next;
    logic                  pop;
    logic [OUTQ_PTR_W:0]   q_load;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = q_cnt_reg != '0;
    assign m_tdata  = q_mem[q_rd_reg];
    assign q_load   = {1'b0, q_cnt_reg} + {{OUTQ_PTR_W{1'b0}}, s1_valid_reg};
    assign s_tready = !realign_reg && (q_load < (OUTQ_PTR_W+1)'(OUTQ_DEPTH));

    always_comb begin
        q_wr_next  = q_wr_reg;
        q_rd_next  = q_rd_reg;
        q_cnt_next = q_cnt_reg;
        if (emit) begin
            q_wr_next = (q_wr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                                                                  : q_wr_reg + OUTQ_PTR_W'(1);
        end
        if (pop) begin
            q_rd_next = (q_rd_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                                                                  : q_rd_reg + OUTQ_PTR_W'(1);
        end
        case ({emit, pop})
            2'b10:   q_cnt_next = q_cnt_reg + OUTQ_PTR_W'(1);
            2'b01:   q_cnt_next = q_cnt_reg - OUTQ_PTR_W'(1);
            default: q_cnt_next = q_cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= LEN_W'(1);
            guard_reg    <= 1'b0;
            realign_reg  <= 1'b0;
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
            pend_reg     <= 1'b0;
            q_wr_reg     <= '0;
            q_rd_reg     <= '0;
            q_cnt_reg    <= '0;
        end else begin
            len_reg      <= len_next;
            guard_reg    <= guard_next;
            realign_reg  <= realign_next;
            seen_reg     <= seen_next;
            s1_valid_reg <= s1_valid_next;
            pend_reg     <= pend_next;
            q_wr_reg     <= q_wr_next;
            q_rd_reg     <= q_rd_next;
            q_cnt_reg    <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_func_reg <= in_func;
            s1_byte_reg <= in_byte;
        end
        pend_start_reg <= pend_start_next;
        if (emit) begin
            q_mem[q_wr_reg] <= pend_start_reg;
        end
    end

    // The input gating must leave room for every result it lets in.
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (q_cnt_reg != OUTQ_PTR_W'(OUTQ_DEPTH)))
        else $error("result pushed into a full queue");

    // Requests wait while the pattern bank realigns.
    a_realign_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        realign_reg |-> !s_tready)
        else $error("request accepted during realign");

    // A length write must be followed by a realign cycle.
    a_len_realign: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_acc && (cfg_index == CFG_IDX_LENGTH)) |=> realign_reg)
        else $error("length write without realign");

    // End of stream leaves no match pending.
    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && (s1_func_reg == FUNC_EOS)) |=> !pend_reg)
        else $error("pending match survived end of stream");

    // Valid window bytes always fill the row from cell 0 without gaps.
    a_window_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, cell_valid} + (CELL_N+1)'(1)))
        else $error("window valid bits are not a prefix");

endmodule

`default_nettype wire
